// ===== rtl/zfcp_pkg.sv =====
// Package for the zone frame chunk packetizer: payload types, codes and sizing constants.
`timescale 1ns / 1ps

package zfcp_pkg;

  // Frame limits
  localparam int ZONE_LIMIT    = 64;
  localparam int CHUNK_PAYLOAD = 18;
  localparam int MAX_CHUNKS    = 'h80;

  // Derived widths
  localparam int ZONE_W = $clog2(ZONE_LIMIT + 1);
  localparam int FILL_W = $clog2(CHUNK_PAYLOAD + 1);
  localparam int NEED_W = 11;            // 16 + 4 * 255 fits
  localparam int HDR_BYTES = 16;
  localparam int ZONE_BYTES = 4;
  localparam int LEFT_W = 5;
  localparam int DATA_W = 8 * HDR_BYTES;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_OUT_CAPACITY   = 1'b0;
  localparam logic REG_FORMAT_VERSION = 1'b1;
  localparam logic [15:0] OUT_CAPACITY_RST   = 16'hFFFF;
  localparam logic [7:0]  FORMAT_VERSION_RST = 8'd2;

  // Commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ZONE  = 1'b1;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_SHAPE    = 2'd1;
  localparam logic [1:0] ERR_CAPACITY = 2'd2;
  localparam logic [1:0] ERR_CHUNKS   = 2'd3;

  // Position inside a chunk
  typedef enum logic [2:0] {
    PH_IDX  = 3'b001,
    PH_SEQ  = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  sensor_kind;
    logic [7:0]  grid_side;
    logic [7:0]  zone_total;
    logic [31:0] frame_seq;
    logic [31:0] timestamp_ms;
    logic [7:0]  profile_code;
    logic [15:0] range_value;
    logic [7:0]  zone_status;
    logic [7:0]  zone_flags;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       frame_end;
    logic [1:0] error_code;
  } out_item_t;

  // Chunk count for each zone total, worked out at elaboration
  typedef logic [NEED_W-1:0] chunk_tbl_t [2**ZONE_W];

  function automatic chunk_tbl_t chunk_table();
    chunk_tbl_t t;
    int need;
    for (int z = 0; z < 2**ZONE_W; z++) begin
      need = 16 + 4 * z;
      t[z] = NEED_W'((need + CHUNK_PAYLOAD - 1) / CHUNK_PAYLOAD);
    end
    return t;
  endfunction

  localparam chunk_tbl_t CHUNK_TBL = chunk_table();

endpackage

// ===== rtl/zone_frame_chunk_packetizer.sv =====
// Zone frame chunk packetizer: frame checks, header build and chunked byte output.
//
//   channel  direction  handshake                      payload
//   in       input      in_valid_i / in_stall_o        in_item_i  (zfcp_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i      out_item_o (zfcp_pkg::out_item_t)
//   cfg      input      psel/penable/pwrite/pready     paddr, pwdata, prdata (APB style)
//
// One result byte leaves per cycle; the byte port sets the rate. A start item yields one
// error byte when it fails its checks, else index, sequence tag and 16 header bytes.
// A zone item yields its four bytes, with an index and sequence tag before any that opens a
// chunk, plus zero padding when it closes the frame; a zone with no open frame yields none.
// A one-item input buffer takes the next transaction while the current one drains; a
// stalled byte holds in the output register and holds the serializer with it.
// Reset clears all control state; there is no clearing pass.
`timescale 1ns / 1ps

module zone_frame_chunk_packetizer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Item input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  zfcp_pkg::in_item_t                    in_item_i,
  // Byte output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output zfcp_pkg::out_item_t                   out_item_o,
  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [zfcp_pkg::PADDR_W-1:0]          paddr,
  input  logic [zfcp_pkg::PDATA_W-1:0]          pwdata,
  output logic [zfcp_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] out_capacity_q;
  logic [7:0]  format_version_q;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[zfcp_pkg::PADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_capacity_q   <= zfcp_pkg::OUT_CAPACITY_RST;
      format_version_q <= zfcp_pkg::FORMAT_VERSION_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        zfcp_pkg::REG_OUT_CAPACITY:   out_capacity_q   <= pwdata[15:0];
        zfcp_pkg::REG_FORMAT_VERSION: format_version_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      zfcp_pkg::REG_OUT_CAPACITY:   prdata = {16'h0000, out_capacity_q};
      zfcp_pkg::REG_FORMAT_VERSION: prdata = {24'h000000, format_version_q};
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input buffer: one transaction waits here while the serializer is busy
  // ---------------------------------------------------------------------------
  logic                in_valid_q;
  zfcp_pkg::in_item_t  in_q;
  logic                load;
  logic                accept;

  assign in_stall_o = in_valid_q && !load;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Start item checks and header image
  // ---------------------------------------------------------------------------
  logic [15:0]                  side_sq;
  logic                         shape_bad;
  logic [zfcp_pkg::NEED_W-1:0]  need;
  logic [zfcp_pkg::NEED_W-1:0]  chunks;
  logic [1:0]                   start_err;
  logic [zfcp_pkg::DATA_W-1:0]  hdr_image;
  logic [zfcp_pkg::DATA_W-1:0]  zone_image;

  assign side_sq = in_q.grid_side * in_q.grid_side;

  assign shape_bad = (in_q.grid_side == 8'd0) || (in_q.zone_total == 8'd0) ||
                     (in_q.zone_total > 8'(zfcp_pkg::ZONE_LIMIT)) ||
                     (in_q.zone_total != side_sq[7:0]);

  assign need   = zfcp_pkg::NEED_W'(16) + {1'b0, in_q.zone_total, 2'b00};
  assign chunks = zfcp_pkg::CHUNK_TBL[in_q.zone_total[zfcp_pkg::ZONE_W-1:0]];

  // Shape first, then capacity, then chunk count
  always_comb begin
    if (shape_bad) begin
      start_err = zfcp_pkg::ERR_SHAPE;
    end else if (out_capacity_q < 16'(need)) begin
      start_err = zfcp_pkg::ERR_CAPACITY;
    end else if (chunks > zfcp_pkg::NEED_W'(zfcp_pkg::MAX_CHUNKS)) begin
      start_err = zfcp_pkg::ERR_CHUNKS;
    end else begin
      start_err = zfcp_pkg::ERR_NONE;
    end
  end

  // Byte 0 sits in the low bits; multi-byte fields go out little-endian
  assign hdr_image = {8'h00, in_q.profile_code, {5'b00000, need[10:8]}, need[7:0],
                      in_q.timestamp_ms, in_q.frame_seq, in_q.zone_total,
                      in_q.grid_side, in_q.sensor_kind, format_version_q};

  assign zone_image = {96'h0, in_q.zone_flags, in_q.zone_status, in_q.range_value};

  // ---------------------------------------------------------------------------
  // Frame state and serializer
  // ---------------------------------------------------------------------------
  logic                         frame_open_q,   frame_open_d;
  logic [zfcp_pkg::ZONE_W-1:0]  zones_left_q,   zones_left_d;
  logic [6:0]                   chunk_number_q, chunk_number_d;
  logic [7:0]                   chunk_total_q,  chunk_total_d;
  logic [zfcp_pkg::FILL_W-1:0]  chunk_fill_q,   chunk_fill_d;
  logic [7:0]                   seq_low_q,      seq_low_d;
  zfcp_pkg::phase_e             ph_q,           ph_d;

  logic                         em_busy_q,      em_busy_d;
  logic [1:0]                   em_err_q,       em_err_d;
  logic [zfcp_pkg::DATA_W-1:0]  em_data_q,      em_data_d;
  logic [zfcp_pkg::LEFT_W-1:0]  em_left_q,      em_left_d;
  logic                         em_pad_q,       em_pad_d;

  logic                         out_valid_q,    out_valid_d;
  zfcp_pkg::out_item_t          out_q,          out_d;

  logic                         out_adv;
  logic                         em_done;
  logic                         last_chunk;
  logic [zfcp_pkg::FILL_W-1:0]  fill_inc;
  logic                         cend;
  logic                         last_zone;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign last_chunk = (chunk_total_q != 8'd0) &&
                      (({1'b0, chunk_number_q} + 8'd1) == chunk_total_q);
  assign fill_inc   = chunk_fill_q + zfcp_pkg::FILL_W'(1);
  assign cend       = (fill_inc == zfcp_pkg::FILL_W'(zfcp_pkg::CHUNK_PAYLOAD));
  assign last_zone  = (zones_left_q <= zfcp_pkg::ZONE_W'(1));
  assign load       = in_valid_q && (!em_busy_q || em_done);

  always_comb begin
    frame_open_d   = frame_open_q;
    zones_left_d   = zones_left_q;
    chunk_number_d = chunk_number_q;
    chunk_total_d  = chunk_total_q;
    chunk_fill_d   = chunk_fill_q;
    seq_low_d      = seq_low_q;
    ph_d           = ph_q;
    em_busy_d      = em_busy_q;
    em_err_d       = em_err_q;
    em_data_d      = em_data_q;
    em_left_d      = em_left_q;
    em_pad_d       = em_pad_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q;
    em_done        = 1'b0;

    if (out_adv) begin
      out_valid_d = 1'b0;
    end

    // Emit one byte per cycle while the output register can take it
    if (em_busy_q && out_adv) begin
      out_valid_d = 1'b1;
      if (em_err_q != zfcp_pkg::ERR_NONE) begin
        out_d = '{out_byte: 8'h00, chunk_end: 1'b0, frame_end: 1'b1, error_code: em_err_q};
        em_done = 1'b1;
      end else begin
        case (ph_q)
          zfcp_pkg::PH_IDX: begin
            out_d = '{out_byte: {last_chunk, chunk_number_q}, chunk_end: 1'b0,
                      frame_end: 1'b0, error_code: zfcp_pkg::ERR_NONE};
            ph_d  = zfcp_pkg::PH_SEQ;
          end
          zfcp_pkg::PH_SEQ: begin
            out_d = '{out_byte: seq_low_q, chunk_end: 1'b0,
                      frame_end: 1'b0, error_code: zfcp_pkg::ERR_NONE};
            ph_d  = zfcp_pkg::PH_DATA;
          end
          zfcp_pkg::PH_DATA: begin
            // Past the item's own bytes only zero padding remains
            out_d = '{out_byte: (em_left_q != '0) ? em_data_q[7:0] : 8'h00,
                      chunk_end: cend,
                      frame_end: cend && em_pad_q && (em_left_q <= zfcp_pkg::LEFT_W'(1)),
                      error_code: zfcp_pkg::ERR_NONE};
            em_data_d = em_data_q >> 8;
            if (em_left_q != '0) begin
              em_left_d = em_left_q - zfcp_pkg::LEFT_W'(1);
            end
            if (cend) begin
              chunk_fill_d   = '0;
              chunk_number_d = chunk_number_q + 7'd1;
              ph_d           = zfcp_pkg::PH_IDX;
            end else begin
              chunk_fill_d   = fill_inc;
            end
            em_done = (em_left_q <= zfcp_pkg::LEFT_W'(1)) && (!em_pad_q || cend);
          end
          default: ph_d = zfcp_pkg::PH_IDX;
        endcase
      end
      if (em_done) begin
        em_busy_d = 1'b0;
      end
    end

    // Take the buffered item into the serializer
    if (load) begin
      if (in_q.cmd == zfcp_pkg::CMD_START) begin
        frame_open_d = 1'b0;
        em_busy_d    = 1'b1;
        em_err_d     = start_err;
        if (start_err == zfcp_pkg::ERR_NONE) begin
          frame_open_d   = 1'b1;
          zones_left_d   = in_q.zone_total[zfcp_pkg::ZONE_W-1:0];
          chunk_number_d = '0;
          chunk_total_d  = chunks[7:0];
          chunk_fill_d   = '0;
          seq_low_d      = in_q.frame_seq[7:0];
          ph_d           = zfcp_pkg::PH_IDX;
          em_data_d      = hdr_image;
          em_left_d      = zfcp_pkg::LEFT_W'(zfcp_pkg::HDR_BYTES);
          em_pad_d       = 1'b0;
        end
      end else if (frame_open_q) begin
        em_busy_d = 1'b1;
        em_err_d  = zfcp_pkg::ERR_NONE;
        em_data_d = zone_image;
        em_left_d = zfcp_pkg::LEFT_W'(zfcp_pkg::ZONE_BYTES);
        em_pad_d  = last_zone;
        if (zones_left_q != '0) begin
          zones_left_d = zones_left_q - zfcp_pkg::ZONE_W'(1);
        end
        if (last_zone) begin
          frame_open_d = 1'b0;
        end
      end
      // Drop zone items that arrive with no open frame
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q   <= 1'b0;
      zones_left_q   <= '0;
      chunk_number_q <= '0;
      chunk_total_q  <= '0;
      chunk_fill_q   <= '0;
      seq_low_q      <= '0;
      ph_q           <= zfcp_pkg::PH_IDX;
      em_busy_q      <= 1'b0;
      em_err_q       <= zfcp_pkg::ERR_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      frame_open_q   <= frame_open_d;
      zones_left_q   <= zones_left_d;
      chunk_number_q <= chunk_number_d;
      chunk_total_q  <= chunk_total_d;
      chunk_fill_q   <= chunk_fill_d;
      seq_low_q      <= seq_low_d;
      ph_q           <= ph_d;
      em_busy_q      <= em_busy_d;
      em_err_q       <= em_err_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_data_q <= em_data_d;
    em_left_q <= em_left_d;
    em_pad_q  <= em_pad_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_err_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.error_code != zfcp_pkg::ERR_NONE) |->
      out_item_o.frame_end && !out_item_o.chunk_end && (out_item_o.out_byte == 8'h00))
    else $error("error transaction without frame_end or with data");

  a_frame_end_closes_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_end &&
      (out_item_o.error_code == zfcp_pkg::ERR_NONE) |-> out_item_o.chunk_end)
    else $error("frame ended inside a chunk");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_fill_q < zfcp_pkg::FILL_W'(zfcp_pkg::CHUNK_PAYLOAD))
    else $error("chunk fill overran the chunk payload");

  a_chunk_head_at_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != zfcp_pkg::PH_DATA) |-> (chunk_fill_q == '0))
    else $error("chunk header pending in the middle of a chunk");

  a_stall_needs_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && em_busy_q)
    else $error("input stalled with room to take the transaction");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the zone frame chunk packetizer: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS  = 470;       // input items in the random part
  localparam int PHASE_ITEMS   = 80;        // items per register setting
  localparam int SETTLE_CYCLES = 40;        // longest item (up to 22 bytes) plus buffering
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int REPORT_LIMIT  = 10;

  // Clock, reset and block ports; every input starts at a known value
  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  zfcp_pkg::in_item_t            in_item   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  zfcp_pkg::out_item_t           out_item;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [zfcp_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [zfcp_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [zfcp_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  zone_frame_chunk_packetizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus queue, bookkeeping and idling control
  zfcp_pkg::in_item_t  pending_items[$];
  zfcp_pkg::out_item_t expected_bytes[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        cycle_count = 0;
  int        in_gap = 0;
  int        stall_left = 0;
  bit        in_took = 1'b0;
  bit        quiet = 1'b0;        // set for stretches with no idling at all
  int        legal_side[$];
  int        legal_zones[$];

  // Predictor copy of the registers and of the framing state
  logic [15:0] cfg_capacity = zfcp_pkg::OUT_CAPACITY_RST;
  logic [7:0]  cfg_version  = zfcp_pkg::FORMAT_VERSION_RST;
  bit          frame_live = 1'b0;
  int          zones_pending = 0;
  logic [6:0]  chunk_idx = '0;
  logic [7:0]  chunk_count = '0;
  int          chunk_fill = 0;
  logic [7:0]  seq_tag = '0;

  function automatic void note_fail(string msg);
    if (fail_count < REPORT_LIMIT) $display("%s", msg);
    fail_count++;
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic cend, logic fend, logic [1:0] code);
    zfcp_pkg::out_item_t r;
    r.out_byte   = b;
    r.chunk_end  = cend;
    r.frame_end  = fend;
    r.error_code = code;
    expected_bytes.push_back(r);
  endfunction

  // Place one payload byte; open a chunk with index and sequence tag when empty,
  // close it with chunk_end once CHUNK_PAYLOAD bytes are in.
  function automatic void chunk_byte(logic [7:0] b, bit ending);
    logic [7:0] idx;
    if (chunk_fill == 0) begin
      idx = {1'b0, chunk_idx};
      if (chunk_count != 0 && {1'b0, chunk_idx} + 8'd1 == chunk_count) idx[7] = 1'b1;
      expect_byte(idx, 1'b0, 1'b0, zfcp_pkg::ERR_NONE);
      expect_byte(seq_tag, 1'b0, 1'b0, zfcp_pkg::ERR_NONE);
    end
    chunk_fill++;
    if (chunk_fill >= zfcp_pkg::CHUNK_PAYLOAD) begin
      expect_byte(b, 1'b1, ending, zfcp_pkg::ERR_NONE);
      chunk_fill = 0;
      chunk_idx++;
    end else begin
      expect_byte(b, 1'b0, 1'b0, zfcp_pkg::ERR_NONE);
    end
  endfunction

  // Work out the bytes one accepted transaction causes
  function automatic void predict_packets(zfcp_pkg::in_item_t it);
    logic [7:0]  hdr[16];
    logic [15:0] need;
    int          chunks;
    bit          last;
    if (it.cmd == zfcp_pkg::CMD_START) begin
      frame_live = 1'b0;
      if (it.grid_side == 0 || it.zone_total == 0 ||
          int'(it.zone_total) > zfcp_pkg::ZONE_LIMIT ||
          int'(it.zone_total) != (int'(it.grid_side) * int'(it.grid_side)) % 256) begin
        expect_byte(8'h00, 1'b0, 1'b1, zfcp_pkg::ERR_SHAPE);
        return;
      end
      need = 16'(16 + 4 * int'(it.zone_total));
      if (cfg_capacity < need) begin
        expect_byte(8'h00, 1'b0, 1'b1, zfcp_pkg::ERR_CAPACITY);
        return;
      end
      chunks = (int'(need) + zfcp_pkg::CHUNK_PAYLOAD - 1) / zfcp_pkg::CHUNK_PAYLOAD;
      if (chunks > zfcp_pkg::MAX_CHUNKS) begin
        expect_byte(8'h00, 1'b0, 1'b1, zfcp_pkg::ERR_CHUNKS);
        return;
      end
      frame_live    = 1'b1;
      zones_pending = it.zone_total;
      chunk_idx     = '0;
      chunk_count   = 8'(chunks);
      chunk_fill    = 0;
      seq_tag       = it.frame_seq[7:0];
      hdr[0]  = cfg_version;
      hdr[1]  = it.sensor_kind;
      hdr[2]  = it.grid_side;
      hdr[3]  = it.zone_total;
      for (int i = 0; i < 4; i++) begin
        hdr[4 + i] = it.frame_seq[8*i +: 8];
        hdr[8 + i] = it.timestamp_ms[8*i +: 8];
      end
      hdr[12] = need[7:0];
      hdr[13] = need[15:8];
      hdr[14] = it.profile_code;
      hdr[15] = 8'h00;
      for (int i = 0; i < 16; i++) chunk_byte(hdr[i], 1'b0);
    end else begin
      // Drop zones that arrive with no frame open
      if (!frame_live) return;
      last = (zones_pending <= 1);
      chunk_byte(it.range_value[7:0], 1'b0);
      chunk_byte(it.range_value[15:8], 1'b0);
      chunk_byte(it.zone_status, 1'b0);
      chunk_byte(it.zone_flags, last);
      if (zones_pending > 0) zones_pending--;
      if (last) begin
        // Pad the final chunk with zeros; its last byte ends the frame
        while (chunk_fill != 0) chunk_byte(8'h00, 1'b1);
        frame_live = 1'b0;
      end
    end
  endfunction

  // Idle lengths: mostly none, often short, now and then long
  function automatic int pick_pause();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 31);
    if (r < 18) return 0;
    if (r < 30) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic zfcp_pkg::in_item_t rand_item();
    logic [159:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(zfcp_pkg::in_item_t)-1:0];
  endfunction

  function automatic zfcp_pkg::in_item_t start_item(int side, int zones);
    zfcp_pkg::in_item_t it;
    it            = rand_item();
    it.cmd        = zfcp_pkg::CMD_START;
    it.grid_side  = 8'(side);
    it.zone_total = 8'(zones);
    return it;
  endfunction

  function automatic zfcp_pkg::in_item_t zone_item();
    zfcp_pkg::in_item_t it;
    it     = rand_item();
    it.cmd = zfcp_pkg::CMD_ZONE;
    return it;
  endfunction

  // Queue one random sequence: mostly well-formed frames, some cut short,
  // some with a bad shape, stray zones and raw noise.
  function automatic void queue_random_frame();
    int pick, k, n_zones;
    pick = $urandom_range(0, 15);
    k = $urandom_range(0, legal_side.size() - 1);
    if (pick < 12) begin
      n_zones = legal_zones[k];
      if (pick >= 9) n_zones = $urandom_range(0, n_zones - 1);   // abandoned by next start
      pending_items.push_back(start_item(legal_side[k], legal_zones[k]));
      items_sent++;
      repeat (n_zones) begin
        pending_items.push_back(zone_item());
        items_sent++;
      end
    end else if (pick == 12) begin
      // Zone count one off the square of the side
      pending_items.push_back(start_item(legal_side[k], legal_zones[k] + 1));
      items_sent++;
    end else if (pick == 13) begin
      pending_items.push_back(start_item($urandom_range(0, 255), $urandom_range(0, 255)));
      items_sent++;
    end else if (pick == 14) begin
      // Stray zones: ignored unless a cut-short frame is still open
      repeat ($urandom_range(1, 3)) pending_items.push_back(zone_item());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        pending_items.push_back(rand_item());
        items_sent++;
      end
    end
  endfunction

  // Write one register over the APB-style port, then read it back
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] rd, mask;
    mask = (idx == zfcp_pkg::REG_OUT_CAPACITY) ? 32'h0000_FFFF : 32'h0000_00FF;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= zfcp_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == zfcp_pkg::REG_OUT_CAPACITY) cfg_capacity = value[15:0];
    else cfg_version = value[7:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== (value & mask))
      note_fail($sformatf("register %0d read back %h, want %h", idx, rd & mask, value & mask));
  endtask

  // Wait until every item is in and every byte is out, then let the block settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: change inputs at the falling edge. Advance to the next item only
  // after the previous transaction went through; hold payload while stalled.
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
    // Receiver stalls in runs; two runs never follow each other back to back
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_pause();
    end
  end

  // Monitor: sample at the rising edge. Predict each accepted input first,
  // then compare each accepted output byte with the oldest expectation.
  always @(posedge clk) begin
    zfcp_pkg::out_item_t want;
    in_took = in_valid && !in_stall;
    if (in_took) predict_packets(in_item);
    if (out_valid === 1'b1 && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        note_fail($sformatf("unexpected byte at %0t: byte %h cend %b fend %b err %0d",
                            $time, out_item.out_byte, out_item.chunk_end,
                            out_item.frame_end, out_item.error_code));
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.chunk_end !== want.chunk_end ||
            out_item.frame_end !== want.frame_end ||
            out_item.error_code !== want.error_code)
          note_fail($sformatf({"mismatch at %0t: got byte %h cend %b fend %b err %0d,",
                               " want byte %h cend %b fend %b err %0d"}, $time,
                              out_item.out_byte, out_item.chunk_end, out_item.frame_end,
                              out_item.error_code, want.out_byte, want.chunk_end,
                              want.frame_end, want.error_code));
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout: %0d bytes still expected", expected_bytes.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    zfcp_pkg::in_item_t it;
    logic [15:0]        dir_cap[3];
    logic [7:0]         dir_ver[3];
    int                 p, phase_base;

    dir_cap = '{16'd0, 16'd20, 16'd19};
    dir_ver = '{8'hFF, 8'h00, 8'h5A};

    // Side/zone pairs that pass the shape check, including wrapped squares
    for (int s = 1; s < 256; s++) begin
      if ((s * s) % 256 >= 1 && (s * s) % 256 <= zfcp_pkg::ZONE_LIMIT) begin
        legal_side.push_back(s);
        legal_zones.push_back((s * s) % 256);
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values
    pending_items.push_back(zone_item());             // zone with no frame open
    pending_items.push_back(start_item(0, 0));        // zero side
    pending_items.push_back(start_item(16, 0));       // square wraps to zero zones
    pending_items.push_back(start_item(8, 65));       // above the zone limit
    pending_items.push_back(start_item(3, 8));        // count not the square of the side
    it              = start_item(1, 1);
    it.sensor_kind  = 8'hFF;
    it.frame_seq    = 32'hFFFF_FFFF;
    it.timestamp_ms = 32'h0000_0000;
    it.profile_code = 8'hFF;
    pending_items.push_back(it);
    it              = zone_item();
    it.range_value  = 16'hFFFF;
    it.zone_status  = 8'h00;
    it.zone_flags   = 8'hFF;
    pending_items.push_back(it);                      // closes the one-zone frame, padded
    it              = start_item(17, 33);             // square modulo 256
    it.sensor_kind  = 8'h00;
    it.frame_seq    = 32'h0000_0000;
    it.timestamp_ms = 32'hFFFF_FFFF;
    it.profile_code = 8'h00;
    pending_items.push_back(it);
    repeat (3) begin
      it             = zone_item();
      it.range_value = 16'h0000;
      it.zone_status = 8'hFF;
      it.zone_flags  = 8'h00;
      pending_items.push_back(it);
    end
    pending_items.push_back(start_item(2, 4));        // abandons the open frame
    repeat (4) pending_items.push_back(zone_item());
    wait_idle();

    // Directed capacity edges: zero, exactly one small frame, one byte short
    for (int d = 0; d < 3; d++) begin
      write_reg(zfcp_pkg::REG_OUT_CAPACITY, {16'h0, dir_cap[d]});
      write_reg(zfcp_pkg::REG_FORMAT_VERSION, {24'h0, dir_ver[d]});
      pending_items.push_back(start_item(1, 1));
      pending_items.push_back(zone_item());
      pending_items.push_back(start_item(2, 4));
      pending_items.push_back(zone_item());
      wait_idle();
    end

    // Random part, one register setting per phase
    p = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (p % 5)
        0:       write_reg(zfcp_pkg::REG_OUT_CAPACITY, 32'h0000_FFFF);
        1:       write_reg(zfcp_pkg::REG_OUT_CAPACITY, $urandom_range(20, 272));
        2:       write_reg(zfcp_pkg::REG_OUT_CAPACITY, $urandom_range(0, 65535));
        3:       write_reg(zfcp_pkg::REG_OUT_CAPACITY, 32'd272);
        default: write_reg(zfcp_pkg::REG_OUT_CAPACITY, $urandom_range(150, 200));
      endcase
      case (p % 3)
        0:       write_reg(zfcp_pkg::REG_FORMAT_VERSION, 32'h0000_00FF);
        1:       write_reg(zfcp_pkg::REG_FORMAT_VERSION, 32'h0000_0000);
        default: write_reg(zfcp_pkg::REG_FORMAT_VERSION, $urandom_range(0, 255));
      endcase
      quiet = (p % 4 == 3);
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS && items_sent < RANDOM_ITEMS)
        queue_random_frame();
      wait_idle();
      p++;
    end

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
